[src/ips_pkg.sv]
// Shared constants, tables and types of the inverse-distance pixel shader.
package ips_pkg;

   // Points taken per pixel before further points are ignored
   localparam int MAX_POINTS = 64;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths
   localparam int COORD_W    = 33;
   localparam int COS_W      = 17;
   localparam int VAL_W      = 20;
   localparam int CH_W       = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;
   localparam int CRIT_W     = 2;
   localparam int RADIUS_W   = 12;

   // Distance path widths
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MPD_W      = 17;
   localparam int LATP_W     = DIFF_W + MPD_W;
   localparam int TERM_W     = LATP_W - 16;
   localparam int LONP_W     = TERM_W + COS_W;
   localparam int MLON_W     = LONP_W - 16;
   localparam int COMP_W     = 22;
   localparam int SQ_W       = 2 * COMP_W;
   localparam int D2_W       = SQ_W + 1;
   localparam int RSQ_W      = 2 * RADIUS_W;
   localparam int RLIM_W     = RSQ_W + 16;

   // Accumulator widths
   localparam int W_W        = 34;
   localparam int WS_W       = W_W + CNT_W;
   localparam int PROD_W     = W_W + 1 + VAL_W;
   localparam int WVS_W      = PROD_W + CNT_W;
   localparam int NVS_W      = VAL_W + CNT_W;

   // Shared divider widths
   localparam int DIV_NW     = (WVS_W > 48) ? WVS_W : 48;
   localparam int DIV_DW     = (WS_W > D2_W) ? WS_W : D2_W;
   localparam int DIV_CNT_W  = $clog2(DIV_NW + 1);

   // Shading widths
   localparam int RES_W      = 22;
   localparam int FLOOR_W    = 15;
   localparam int SPAN_W     = 13;
   localparam int X3_W       = SPAN_W + 2;
   localparam int T_W        = SPAN_W + 1;
   localparam int DELTA_W    = 9;
   localparam int NUM_W      = DELTA_W + T_W + 1;

   localparam logic [MPD_W-1:0]  METRES_PER_DEG = 17'd111320;
   localparam logic [15:0]       ROUND_HALF     = 16'h8000;
   localparam logic [COMP_W-1:0] COMP_CAP       = 22'h200000;
   localparam logic [D2_W-1:0]   NEAR_LIMIT     = D2_W'(64'd16384);
   localparam logic [DIV_NW-1:0] WEIGHT_ONE     = DIV_NW'(64'h8000_0000_0000);
   localparam logic [CH_W-1:0]   SHADED_ALPHA   = 8'd200;
   localparam logic [CH_W-1:0]   CH_MAX         = 8'd255;

   // Criterion floor and span, Q4
   localparam logic signed [FLOOR_W-1:0] FLOOR_Q4 [4] =
      '{-15'sd1760, -15'sd320, -15'sd1600, 15'sd0};
   localparam logic [SPAN_W-1:0] SPAN_Q4 [4] =
      '{13'd480, 13'd272, 13'd800, 13'd8000};

   // Ramp knots, one row per knot, red/green/blue
   localparam logic [CH_W-1:0] KNOT [4][3] = '{
      '{8'd40,  8'd60,  8'd180},
      '{8'd60,  8'd200, 8'd220},
      '{8'd240, 8'd220, 8'd60},
      '{8'd220, 8'd30,  8'd30}
   };

   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;

   localparam logic [1:0] SEG_LOW  = 2'd0;
   localparam logic [1:0] SEG_MID  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CRITERION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS    = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd100;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_MUL1, ST_MUL2, ST_SQ, ST_SUM, ST_CLASS, ST_WDIV,
      ST_WACC, ST_FIN, ST_VDIV, ST_SHADE, ST_CHK, ST_CSTART, ST_CDIV, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_DIFF, OP_MUL1, OP_MUL2, OP_SQ, OP_SUM, OP_NEAR,
      OP_WSTART, OP_WMUL, OP_WACC, OP_VSTART, OP_VAL, OP_SHADE, OP_CSTART,
      OP_CSTORE, OP_ZERO, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic take;
      logic near;
      logic has_weight;
      logic below;
      logic last;
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pixel_lat;
      logic signed [COORD_W-1:0] pixel_lon;
      logic        [COS_W-1:0]   cos_lat;
      logic signed [COORD_W-1:0] point_lat;
      logic signed [COORD_W-1:0] point_lon;
      logic signed [VAL_W-1:0]   sample_value;
      logic                      last_point;
   } req_word_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
   } rsp_word_type;

endpackage

[src/ips_req_if.sv]
// Input channel: one sample point word per handshake.
interface ips_req_if import ips_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pixel_lat;
   logic signed [COORD_W-1:0] pixel_lon;
   logic        [COS_W-1:0]   cos_lat;
   logic signed [COORD_W-1:0] point_lat;
   logic signed [COORD_W-1:0] point_lon;
   logic signed [VAL_W-1:0]   sample_value;
   logic                      last_point;

   modport source (output valid, pixel_lat, pixel_lon, cos_lat, point_lat, point_lon,
                   sample_value, last_point, input ready);
   modport sink (input valid, pixel_lat, pixel_lon, cos_lat, point_lat, point_lon,
                 sample_value, last_point, output ready);
endinterface

[src/ips_rsp_if.sv]
// Result channel: one RGBA word per handshake.
interface ips_rsp_if import ips_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;
   logic [CH_W-1:0] alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

[src/ips_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
module ips_div import ips_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic              done,
   output logic [DIV_NW-1:0] quotient,
   output logic [DIV_DW-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NW-1:0]    quo_ff, quo_in;
   logic [DIV_DW-1:0]    rem_ff, rem_in;
   logic [DIV_DW-1:0]    dvs_ff, dvs_in;
   logic [DIV_DW:0]      shifted;
   logic [DIV_DW+1:0]    diff;

   // Shift in the next dividend bit and trial-subtract
   assign shifted = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_NW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NW-2:0], ~diff[DIV_DW+1]};
         rem_in = diff[DIV_DW+1] ? shifted[DIV_DW-1:0] : diff[DIV_DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[src/ips_ctrl.sv]
// Sequencer of the pixel shader: steps the datapath through one word at a time.
module ips_ctrl import ips_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      cmd.op    = OP_NONE;
      cmd.chan  = chan_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.op   = OP_SQ;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            if (status.take && !status.near) begin
               cmd.op   = OP_WSTART;
               state_in = ST_WDIV;
            end else begin
               if (status.take) cmd.op = OP_NEAR;
               state_in = status.last ? ST_FIN : ST_IDLE;
            end
         end
         ST_WDIV: begin
            if (status.div_done) begin
               cmd.op   = OP_WMUL;
               state_in = ST_WACC;
            end
         end
         ST_WACC: begin
            cmd.op   = OP_WACC;
            state_in = status.last ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (status.has_weight) begin
               cmd.op   = OP_VSTART;
               state_in = ST_VDIV;
            end else begin
               cmd.op   = OP_ZERO;
               state_in = ST_OUT;
            end
         end
         ST_VDIV: begin
            if (status.div_done) begin
               cmd.op   = OP_VAL;
               state_in = ST_SHADE;
            end
         end
         ST_SHADE: begin
            cmd.op   = OP_SHADE;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (status.below) begin
               cmd.op   = OP_ZERO;
               state_in = ST_OUT;
            end else begin
               chan_in  = CHAN_RED;
               state_in = ST_CSTART;
            end
         end
         ST_CSTART: begin
            cmd.op   = OP_CSTART;
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            if (status.div_done) begin
               cmd.op = OP_CSTORE;
               if (chan_ff == CHAN_BLUE) begin
                  state_in = ST_OUT;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_CSTART;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result word until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CHAN_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/ips_dp.sv]
// Datapath of the pixel shader: distance, weights, accumulators, ramp and output word.
module ips_dp import ips_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_word_type          req_word,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_word_type          rsp_word
);

   logic [CRIT_W-1:0]   criterion_ff;
   logic [RADIUS_W-1:0] radius_ff;

   req_word_type        req_ff;
   logic [DIFF_W-1:0]   alat_ff, alon_ff;
   logic [COMP_W-1:0]   mlat_ff, mlon_ff;
   logic [TERM_W-1:0]   lon_t_ff;
   logic [SQ_W-1:0]     sqlat_ff, sqlon_ff;
   logic [D2_W-1:0]     d2_ff;

   logic [WS_W-1:0]          ws_ff;
   logic signed [WVS_W-1:0]  wvs_ff;
   logic [CNT_W-1:0]         ncnt_ff;
   logic signed [NVS_W-1:0]  nvs_ff;
   logic [CNT_W-1:0]         pcnt_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [RES_W-1:0] value_ff;
   logic                    below_ff;
   logic [X3_W-1:0]         x3_ff;
   logic [1:0]              seg_ff;
   logic                    neg_ff;
   logic [CH_W-1:0]         color_ff [3];
   logic                    shaded_ff;
   rsp_word_type            rsp_ff;

   // Divider hookup
   logic              div_start, div_done, neg_in;
   logic [DIV_NW-1:0] dvd, quo;
   logic [DIV_DW-1:0] dvs, rem;

   ips_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   // Combinational terms
   logic signed [DIFF_W-1:0]  dlat, dlon;
   logic [LATP_W-1:0]         lat_p, lon_p0;
   logic [TERM_W-1:0]         lat_t;
   logic [LONP_W-1:0]         lon_p;
   logic [MLON_W-1:0]         lon_m;
   logic [RSQ_W-1:0]          rsq;
   logic [RLIM_W-1:0]         rlim;
   logic [SPAN_W-1:0]         sp;
   logic signed [FLOOR_W-1:0] fl;
   logic [W_W-1:0]            w;
   logic [NVS_W-1:0]          nvs_mag;
   logic [WVS_W-1:0]          wvs_mag;
   logic [T_W-1:0]            t;
   logic signed [DELTA_W-1:0] delta;
   logic signed [NUM_W-1:0]   num;
   logic [NUM_W-1:0]          num_mag;
   logic [RES_W-1:0]          qmag;
   logic signed [RES_W-1:0]   fq;
   logic signed [RES_W:0]     x;
   logic [SPAN_W-1:0]         xc;
   logic [X3_W-1:0]           x3;
   logic [1:0]                seg;
   logic signed [RES_W-1:0]   ch;
   logic [CH_W-1:0]           ch_sat;
   logic [CH_W-1:0]           knot_v;

   assign sp = SPAN_Q4[criterion_ff];
   assign fl = FLOOR_Q4[criterion_ff];

   assign dlat   = $signed({req_ff.point_lat[COORD_W-1], req_ff.point_lat})
                 - $signed({req_ff.pixel_lat[COORD_W-1], req_ff.pixel_lat});
   assign dlon   = $signed({req_ff.point_lon[COORD_W-1], req_ff.point_lon})
                 - $signed({req_ff.pixel_lon[COORD_W-1], req_ff.pixel_lon});
   assign lat_p  = alat_ff * METRES_PER_DEG + LATP_W'(ROUND_HALF);
   assign lon_p0 = alon_ff * METRES_PER_DEG + LATP_W'(ROUND_HALF);
   assign lat_t  = lat_p[LATP_W-1:16];
   assign lon_p  = lon_t_ff * req_ff.cos_lat + LONP_W'(ROUND_HALF);
   assign lon_m  = lon_p[LONP_W-1:16];

   assign rsq  = radius_ff * radius_ff;
   assign rlim = {rsq, 16'd0};

   assign w       = quo[W_W-1:0];
   assign nvs_mag = nvs_ff[NVS_W-1] ? NVS_W'(-nvs_ff) : NVS_W'(nvs_ff);
   assign wvs_mag = wvs_ff[WVS_W-1] ? WVS_W'(-wvs_ff) : WVS_W'(wvs_ff);

   // Ramp segment offset and slope for the current channel
   always_comb begin
      case (seg_ff)
         SEG_LOW: t = T_W'(x3_ff);
         SEG_MID: t = T_W'(x3_ff - X3_W'(sp));
         default: t = T_W'(x3_ff - X3_W'({sp, 1'b0}));
      endcase
   end
   assign delta   = $signed({1'b0, KNOT[seg_ff + 2'd1][cmd.chan]})
                  - $signed({1'b0, KNOT[seg_ff][cmd.chan]});
   assign num     = delta * $signed({1'b0, t});
   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

   // Signed floor quotient from the divider
   assign qmag = {1'b0, quo[RES_W-2:0]} + RES_W'(neg_ff && (rem != '0));
   assign fq   = neg_ff ? $signed(-qmag) : $signed(qmag);

   // Clamp the value into the span and pick the segment
   assign x  = $signed({value_ff[RES_W-1], value_ff})
             - $signed({{(RES_W + 1 - FLOOR_W){fl[FLOOR_W-1]}}, fl});
   assign xc = (x > $signed({{(RES_W + 1 - SPAN_W){1'b0}}, sp})) ? sp : x[SPAN_W-1:0];
   assign x3 = {1'b0, xc, 1'b0} + {2'b00, xc};
   always_comb begin
      if (x3 < X3_W'(sp))                 seg = SEG_LOW;
      else if (x3 < X3_W'({sp, 1'b0}))    seg = SEG_MID;
      else                                seg = SEG_HIGH;
   end

   assign knot_v = KNOT[seg_ff][cmd.chan];
   assign ch     = $signed({{(RES_W - CH_W){1'b0}}, knot_v}) + fq;
   always_comb begin
      if (ch[RES_W-1])                                  ch_sat = '0;
      else if (ch > $signed(RES_W'(CH_MAX)))            ch_sat = CH_MAX;
      else                                              ch_sat = ch[CH_W-1:0];
   end

   // Divider operand select
   always_comb begin
      div_start = 1'b0;
      dvd       = WEIGHT_ONE;
      dvs       = DIV_DW'(d2_ff);
      neg_in    = neg_ff;
      case (cmd.op)
         OP_WSTART: begin
            div_start = 1'b1;
            neg_in    = 1'b0;
         end
         OP_VSTART: begin
            div_start = 1'b1;
            if (ncnt_ff != '0) begin
               dvd    = DIV_NW'(nvs_mag);
               dvs    = DIV_DW'(ncnt_ff);
               neg_in = nvs_ff[NVS_W-1];
            end else begin
               dvd    = DIV_NW'(wvs_mag);
               dvs    = DIV_DW'(ws_ff);
               neg_in = wvs_ff[WVS_W-1];
            end
         end
         OP_CSTART: begin
            div_start = 1'b1;
            dvd       = DIV_NW'(num_mag);
            dvs       = DIV_DW'(sp);
            neg_in    = num[NUM_W-1];
         end
         default: ;
      endcase
   end

   // Configuration and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         criterion_ff <= '0;
         radius_ff    <= RADIUS_RESET;
         ws_ff        <= '0;
         wvs_ff       <= '0;
         ncnt_ff      <= '0;
         nvs_ff       <= '0;
         pcnt_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CRITERION: criterion_ff <= csr_wdata[CRIT_W-1:0];
               CSR_RADIUS:    radius_ff    <= csr_wdata[RADIUS_W-1:0];
               default: ;
            endcase
         end
         case (cmd.op)
            OP_NEAR: begin
               ncnt_ff <= ncnt_ff + 1'b1;
               pcnt_ff <= pcnt_ff + 1'b1;
               nvs_ff  <= nvs_ff + {{CNT_W{req_ff.sample_value[VAL_W-1]}},
                                    req_ff.sample_value};
            end
            OP_WMUL: begin
               ws_ff   <= ws_ff + WS_W'(w);
               pcnt_ff <= pcnt_ff + 1'b1;
            end
            OP_WACC: wvs_ff <= wvs_ff + {{CNT_W{prod_ff[PROD_W-1]}}, prod_ff};
            OP_OUT: begin
               ws_ff   <= '0;
               wvs_ff  <= '0;
               ncnt_ff <= '0;
               nvs_ff  <= '0;
               pcnt_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      case (cmd.op)
         OP_LOAD: req_ff <= req_word;
         OP_DIFF: begin
            alat_ff <= dlat[DIFF_W-1] ? DIFF_W'(-dlat) : DIFF_W'(dlat);
            alon_ff <= dlon[DIFF_W-1] ? DIFF_W'(-dlon) : DIFF_W'(dlon);
         end
         OP_MUL1: begin
            mlat_ff  <= (lat_t > TERM_W'(COMP_CAP)) ? COMP_CAP : lat_t[COMP_W-1:0];
            lon_t_ff <= lon_p0[LATP_W-1:16];
         end
         OP_MUL2: mlon_ff <= (lon_m > MLON_W'(COMP_CAP)) ? COMP_CAP : lon_m[COMP_W-1:0];
         OP_SQ: begin
            sqlat_ff <= mlat_ff * mlat_ff;
            sqlon_ff <= mlon_ff * mlon_ff;
         end
         OP_SUM:  d2_ff   <= {1'b0, sqlat_ff} + {1'b0, sqlon_ff};
         OP_WMUL: prod_ff <= $signed({1'b0, w}) * req_ff.sample_value;
         OP_VAL:  value_ff <= fq;
         OP_SHADE: begin
            below_ff <= x[RES_W];
            x3_ff    <= x3;
            seg_ff   <= seg;
         end
         OP_CSTART: shaded_ff <= 1'b1;
         OP_CSTORE: color_ff[cmd.chan] <= ch_sat;
         OP_ZERO: begin
            shaded_ff   <= 1'b0;
            color_ff[0] <= '0;
            color_ff[1] <= '0;
            color_ff[2] <= '0;
         end
         OP_OUT: begin
            rsp_ff.red   <= color_ff[0];
            rsp_ff.green <= color_ff[1];
            rsp_ff.blue  <= color_ff[2];
            rsp_ff.alpha <= shaded_ff ? SHADED_ALPHA : '0;
         end
         default: ;
      endcase
   end

   assign status.div_done   = div_done;
   assign status.take       = (d2_ff <= D2_W'(rlim)) && (pcnt_ff < CNT_W'(MAX_POINTS));
   assign status.near       = d2_ff < NEAR_LIMIT;
   assign status.has_weight = (ncnt_ff != '0) || (ws_ff != '0);
   assign status.below      = below_ff;
   assign status.last       = req_ff.last_point;
   assign rsp_word          = rsp_ff;

endmodule

[src/idw_pixel_shader.sv]
// Top level of the inverse-distance-weighted pixel shader.
//
//   channel  dir  handshake        word
//   req_ch   in   valid/ready      pixel and point coordinates, cosine, value, last flag
//   rsp_ch   out  valid/ready      red, green, blue, alpha (one per pixel)
//   csr_*    in   csr_we           criterion (index 0), radius_m (index 1)
//
// Skipped and near points bypass the divider; a weighted point runs the radix-2
// divider, which forms 2^47/d2 at one bit per cycle over 62 bits.
// A shaded last point adds one value division and three ramp divisions;
// an empty pixel adds no division; a pixel below the floor adds only the value division.
// Reset is synchronous; no clearing pass follows it.
// The result stage stalls while the previous result still waits on rsp_ch;
// a new word is taken while that result waits.
module idw_pixel_shader import ips_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ips_req_if.sink               req_ch,
   ips_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   req_word_type req_word;
   rsp_word_type rsp_word;
   cmd_type      cmd;
   status_type   status;

   // Gather the input word
   assign req_word.pixel_lat    = req_ch.pixel_lat;
   assign req_word.pixel_lon    = req_ch.pixel_lon;
   assign req_word.cos_lat      = req_ch.cos_lat;
   assign req_word.point_lat    = req_ch.point_lat;
   assign req_word.point_lon    = req_ch.point_lon;
   assign req_word.sample_value = req_ch.sample_value;
   assign req_word.last_point   = req_ch.last_point;

   ips_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ips_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   // Drive the result word
   assign rsp_ch.red   = rsp_word.red;
   assign rsp_ch.green = rsp_word.green;
   assign rsp_ch.blue  = rsp_word.blue;
   assign rsp_ch.alpha = rsp_word.alpha;

endmodule

[sim/testbench.sv]
// Testbench for the inverse-distance pixel shader: random and directed points, predicted RGBA.
`timescale 1ns / 100ps
module testbench;
   import ips_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int RANDOM_ITEMS   = 390;
   localparam longint COORD_MAX  = 64'sd3019898880;
   localparam longint UNITS_PER_M = 151;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ips_req_if req_ch();
   ips_rsp_if rsp_ch();

   idw_pixel_shader u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shader state as predicted
   logic [CRIT_W-1:0]   mdl_criterion;
   logic [RADIUS_W-1:0] mdl_radius;
   longint              mdl_weight_sum;
   longint              mdl_wvalue_sum;
   int                  mdl_near_count;
   longint              mdl_near_sum;
   int                  mdl_points;

   rsp_word_type pixel_queue[$];
   int  errors;
   bit  no_idle;
   int  idle_cycles;

   localparam longint FLOOR_TBL [4] = '{-1760, -320, -1600, 0};
   localparam longint SPAN_TBL  [4] = '{480, 272, 800, 8000};

   always #5 clock = ~clock;

   function automatic longint floor_div(longint n, longint d);
      if (n >= 0) return n / d;
      return -((-n + d - 1) / d);
   endfunction

   function automatic longint abs_diff(longint a, longint b);
      longint d;
      d = a - b;
      return (d < 0) ? -d : d;
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < -COORD_MAX) return -COORD_MAX;
      return v;
   endfunction

   // Map a Q4 value through the three-segment ramp
   function automatic rsp_word_type ramp_color(longint v);
      rsp_word_type c;
      longint x, sp, x3, delta, ch;
      int seg;
      c = '0;
      x  = v - FLOOR_TBL[mdl_criterion];
      sp = SPAN_TBL[mdl_criterion];
      if (x < 0) return c;
      if (x > sp) x = sp;
      x3 = 3 * x;
      seg = (x3 < sp) ? 0 : (x3 < 2 * sp) ? 1 : 2;
      for (int k = 0; k < 3; k++) begin
         delta = longint'(KNOT[seg+1][k]) - longint'(KNOT[seg][k]);
         ch = longint'(KNOT[seg][k]) + floor_div(delta * (x3 - seg * sp), sp);
         if (ch < 0) ch = 0;
         if (ch > 255) ch = 255;
         if (k == 0) c.red = ch[7:0];
         else if (k == 1) c.green = ch[7:0];
         else c.blue = ch[7:0];
      end
      c.alpha = SHADED_ALPHA;
      return c;
   endfunction

   // Accumulate one accepted point; queue the pixel color on the last one
   task automatic accumulate_point(req_word_type w);
      longint mlat, mlon, d2, rlim, wt, val;
      rsp_word_type c;
      mlat = (abs_diff(w.point_lat, w.pixel_lat) * 111320 + 32768) >>> 16;
      if (mlat > 64'd2097152) mlat = 64'd2097152;
      mlon = (abs_diff(w.point_lon, w.pixel_lon) * 111320 + 32768) >>> 16;
      mlon = (mlon * longint'(w.cos_lat) + 32768) >>> 16;
      if (mlon > 64'd2097152) mlon = 64'd2097152;
      d2 = mlat * mlat + mlon * mlon;
      rlim = (longint'(mdl_radius) * longint'(mdl_radius)) <<< 16;
      val = w.sample_value;
      if (d2 <= rlim && mdl_points < MAX_POINTS) begin
         mdl_points++;
         if (d2 < 16384) begin
            mdl_near_count++;
            mdl_near_sum += val;
         end else begin
            wt = (64'sd1 <<< 47) / d2;
            mdl_weight_sum += wt;
            mdl_wvalue_sum += wt * val;
         end
      end
      if (!w.last_point) return;
      if (mdl_near_count > 0) c = ramp_color(floor_div(mdl_near_sum, mdl_near_count));
      else if (mdl_weight_sum == 0) c = '0;
      else c = ramp_color(floor_div(mdl_wvalue_sum, mdl_weight_sum));
      pixel_queue = {pixel_queue, c};
      mdl_weight_sum = 0;
      mdl_wvalue_sum = 0;
      mdl_near_count = 0;
      mdl_near_sum   = 0;
      mdl_points     = 0;
   endtask

   // Send one point word, holding valid until it is taken
   task automatic send_point(req_word_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.pixel_lat    <= w.pixel_lat;
      req_ch.pixel_lon    <= w.pixel_lon;
      req_ch.cos_lat      <= w.cos_lat;
      req_ch.point_lat    <= w.point_lat;
      req_ch.point_lon    <= w.point_lon;
      req_ch.sample_value <= w.sample_value;
      req_ch.last_point   <= w.last_point;
      do @(posedge clock); while (!req_ch.ready);
      accumulate_point(w);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      wait (pixel_queue.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CRITERION) mdl_criterion = data[CRIT_W-1:0];
      else mdl_radius = data[RADIUS_W-1:0];
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      longint sp, v;
      if ($urandom_range(0, 9) == 0) return VAL_W'($urandom);
      sp = SPAN_TBL[mdl_criterion];
      v = FLOOR_TBL[mdl_criterion] - sp / 4 + longint'($urandom_range(0, 3 * sp / 2));
      return VAL_W'(v);
   endfunction

   function automatic longint rand_coord();
      longint unsigned r;
      r = {$urandom, $urandom};
      return longint'(r % 64'd6039797761) - COORD_MAX;
   endfunction

   // Send one pixel of npts points scattered within spread metres
   task automatic send_pixel(int npts, int spread, bit wild);
      req_word_type w;
      longint s;
      w.pixel_lat = COORD_W'(rand_coord());
      w.pixel_lon = COORD_W'(rand_coord());
      case ($urandom_range(0, 7))
         0: w.cos_lat = 17'd0;
         1: w.cos_lat = 17'd65536;
         default: w.cos_lat = COS_W'($urandom_range(16384, 65536));
      endcase
      s = longint'(spread) * UNITS_PER_M;
      for (int i = 0; i < npts; i++) begin
         if (wild && $urandom_range(0, 5) == 0) begin
            w.point_lat = COORD_W'(rand_coord());
            w.point_lon = COORD_W'(rand_coord());
         end else if ($urandom_range(0, 9) == 0) begin
            w.point_lat = w.pixel_lat;
            w.point_lon = COORD_W'(clamp_coord(w.pixel_lon
                                               + longint'($urandom_range(0, 100))));
         end else begin
            w.point_lat = COORD_W'(clamp_coord(w.pixel_lat
                                               + longint'($urandom_range(0, 2 * s)) - s));
            w.point_lon = COORD_W'(clamp_coord(w.pixel_lon
                                               + longint'($urandom_range(0, 2 * s)) - s));
         end
         w.sample_value = pick_value();
         w.last_point   = (i == npts - 1);
         send_point(w);
      end
   endtask

   // Extremes, near points, empty pixel, floor, saturation
   task automatic test_directed();
      req_word_type w;
      w = '0;
      w.cos_lat = 17'd65536;
      // exact hit dominates
      w.sample_value = 20'sd0;
      send_point(w);
      w.pixel_lon = 33'sd100;
      w.sample_value = -20'sd1500;
      w.last_point = 1'b1;
      send_point(w);
      // far coordinate extremes: component cap, nothing in range
      w.pixel_lat = COORD_W'(COORD_MAX);  w.pixel_lon = COORD_W'(-COORD_MAX);
      w.point_lat = COORD_W'(-COORD_MAX); w.point_lon = COORD_W'(COORD_MAX);
      w.sample_value = 20'sh7FFFF; w.last_point = 1'b0;
      send_point(w);
      w.sample_value = 20'sh80000; w.last_point = 1'b1;
      send_point(w);
      // weighted points, high and below-floor values
      w = '0; w.cos_lat = 17'd0;
      w.point_lat = 33'sd5000; w.point_lon = -33'sd4000;
      w.sample_value = 20'sh7FFFF;
      send_point(w);
      w.point_lat = -33'sd3000; w.sample_value = -20'sd1000; w.last_point = 1'b1;
      send_point(w);
      w.point_lat = 33'sd6000; w.sample_value = 20'sh80000;
      send_point(w);
      // saturation of the point count
      send_pixel(MAX_POINTS + 6, 20, 1'b0);
      send_pixel(1, 50, 1'b0);
   endtask

   // Each criterion across radius extremes
   task automatic test_settings();
      int radii [4] = '{1, 0, 4095, 250};
      for (int r = 0; r < 4; r++) begin
         write_csr(CSR_RADIUS, CSR_DATA_W'(radii[r]));
         for (int c = 0; c < 4; c++) begin
            write_csr(CSR_CRITERION, CSR_DATA_W'(c));
            for (int p = 0; p < 6; p++)
               send_pixel($urandom_range(1, 5), (radii[r] == 0) ? 1 : radii[r], p == 5);
         end
      end
   endtask

   // Bulk random pixels, with bursts and one full pause
   task automatic test_random();
      int sent;
      sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_CRITERION, CSR_DATA_W'($urandom_range(0, 3)));
         write_csr(CSR_RADIUS, CSR_DATA_W'($urandom_range(1, 4095)));
         for (int p = 0; p < 40 && sent < RANDOM_ITEMS; p++) begin
            int n;
            n = ($urandom_range(0, 20) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
            no_idle = (p % 10) < 2;
            send_pixel(n, $urandom_range(1, int'(mdl_radius) + 10), $urandom_range(0, 4) == 0);
            sent += n;
            if (ph == 0 && p == 20) drain_results();
         end
         no_idle = 0;
         if (sent >= RANDOM_ITEMS) break;
      end
   endtask

   // Result side: random stalls, compare against the oldest prediction
   initial begin
      rsp_ready_loop();
   end

   task automatic rsp_ready_loop();
      int stall;
      rsp_word_type exp_c;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel word %0h", {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha});
            errors++;
         end else begin
            exp_c = pixel_queue.pop_front();
            if (rsp_ch.red !== exp_c.red) begin
               $error("red expected %0d actual %0d", exp_c.red, rsp_ch.red); errors++;
            end
            if (rsp_ch.green !== exp_c.green) begin
               $error("green expected %0d actual %0d", exp_c.green, rsp_ch.green); errors++;
            end
            if (rsp_ch.blue !== exp_c.blue) begin
               $error("blue expected %0d actual %0d", exp_c.blue, rsp_ch.blue); errors++;
            end
            if (rsp_ch.alpha !== exp_c.alpha) begin
               $error("alpha expected %0d actual %0d", exp_c.alpha, rsp_ch.alpha); errors++;
            end
         end
      end
   endtask

   // Watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel_lat = '0;
      req_ch.pixel_lon = '0;
      req_ch.cos_lat = '0;
      req_ch.point_lat = '0;
      req_ch.point_lon = '0;
      req_ch.sample_value = '0;
      req_ch.last_point = 1'b0;
      rsp_ch.ready = 1'b0;
      errors = 0;
      no_idle = 0;
      idle_cycles = 0;
      mdl_criterion = '0;
      mdl_radius = RADIUS_RESET;
      mdl_weight_sum = 0;
      mdl_wvalue_sum = 0;
      mdl_near_count = 0;
      mdl_near_sum = 0;
      mdl_points = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_random();
      drain_results();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

[sim.f]
src/ips_pkg.sv
src/ips_req_if.sv
src/ips_rsp_if.sv
src/ips_div.sv
src/ips_ctrl.sv
src/ips_dp.sv
src/idw_pixel_shader.sv
sim/testbench.sv
